@@ rtl/ifr_pkg.sv @@
`default_nettype none
package ifr_pkg;

	localparam int MAX_WIDTH   = 512;
	localparam int MAX_HEIGHT  = 512;
	localparam int FRAC_BITS   = 16;

	localparam int X_BITS      = $clog2(MAX_WIDTH);
	localparam int Y_BITS      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W      = X_BITS + Y_BITS;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_W       = 24;

	localparam int CRD_W       = 13;
	localparam int INV_W       = 23;
	localparam int DIM_W       = 10;
	localparam int CFG_IDX_W   = 3;

	localparam longint ONE     = longint'(1) << FRAC_BITS;

	// source position and its integer part
	localparam int SX_W        = CRD_W + INV_W;
	localparam int IX_W        = SX_W - FRAC_BITS;
	localparam int TX_W        = IX_W + 3;

	// kernel arithmetic
	localparam int D_W         = FRAC_BITS + 2;
	localparam int Q2_W        = FRAC_BITS + 3;
	localparam int Q3_W        = FRAC_BITS + 4;
	localparam int KW_W        = FRAC_BITS + 8;
	localparam int WT_W        = FRAC_BITS + 3;
	localparam int W_W         = 2 * WT_W;

	// shared multiplier operands
	localparam int MA_W        = (W_W > INV_W + 1) ? W_W : INV_W + 1;
	localparam int MB_W        = (WT_W + 1 > CRD_W + 1) ? WT_W + 1 : CRD_W + 1;
	localparam int MP_W        = MA_W + MB_W;

	localparam int ACC_W       = W_W + 14;
	localparam int DIV_W       = ACC_W - 1;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_W  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_H  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV    = 3'd4;

	localparam logic [1:0] MODE_NEAREST  = 2'd0;
	localparam logic [1:0] MODE_BILINEAR = 2'd1;

	typedef struct packed {
		logic             action;
		logic [CRD_W-1:0] coord_x;
		logic [CRD_W-1:0] coord_y;
		logic [7:0]       chan_blue;
		logic [7:0]       chan_green;
		logic [7:0]       chan_red;
	} in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
	} out_t;

endpackage
`default_nettype wire

@@ rtl/image_resize_interpolator.sv @@
`default_nettype none
// Frame-store resampler: nearest, bilinear or bicubic (Keys, a = -0.5).
// Input: an item is taken when start is high and busy is low. action 0 loads
// one source pixel into the frame store (busy stays low); action 1
// asks for the destination pixel at coord_x/coord_y.
// Output: a request answers with result_valid high for exactly one cycle,
// carrying result; the receiver cannot stall, so nothing is held back.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register; cfg_ready is high only while idle.
// Every request runs through one shared multiplier (operands muxed by the
// sequencer, product registered):
//   nearest   rounds the source position and reads one pixel
//   bilinear  4 taps, each a weight product and three channel products
//   bicubic   8 kernel weights (square, cube, weight), 16 taps as for
//             bilinear, then a restoring divider per channel
// A request is taken only while idle; loads sustain one per cycle then.
// Reset clears the registers to width 1, height 1, nearest, BGR, scale 1.0.
// The frame store is not cleared: a pixel must be loaded before it is read.
module image_resize_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ifr_pkg::in_t                  item,
	output logic                          result_valid,
	output ifr_pkg::out_t                 result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ifr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ifr_pkg::INV_W-1:0]     cfg_data
);
	import ifr_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MX, ST_MY, ST_POS, ST_SEL, ST_NRD, ST_NOUT,
		ST_KSQ, ST_KCU, ST_KWT, ST_TW, ST_TP0, ST_TP1, ST_TP2, ST_TP3,
		ST_FIN, ST_DGO, ST_DWAIT
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0] src_w_q, src_h_q;
	logic [1:0]       interp_q;
	logic             color_q;
	logic [INV_W-1:0] inv_q;

	in_t              item_q;
	logic [SX_W-1:0]  sx_q, sy_q;
	logic [2:0]       k_q;
	logic [1:0]       n_q, m_q, c_q;
	logic [Q2_W-1:0]  q2_q;
	logic signed [WT_W-1:0]  wx_q [4];
	logic signed [WT_W-1:0]  wy_q [4];
	logic signed [MA_W-1:0]  w_q;
	logic [PIX_W-1:0]        pix_q;
	logic signed [ACC_W-1:0] acc_q [3];
	logic signed [ACC_W-1:0] wsum_q;
	logic [7:0]       res0_q, res1_q;
	logic             rvalid_q;
	out_t             result_q;

	logic cubic;
	assign cubic = interp_q[1];

	// effective last column / row
	logic [X_BITS-1:0] xlast;
	logic [Y_BITS-1:0] ylast;
	always_comb begin
		if (src_w_q == '0) xlast = '0;
		else if (32'(src_w_q) > MAX_WIDTH) xlast = X_BITS'(MAX_WIDTH - 1);
		else xlast = X_BITS'(src_w_q - 1'b1);
		if (src_h_q == '0) ylast = '0;
		else if (32'(src_h_q) > MAX_HEIGHT) ylast = Y_BITS'(MAX_HEIGHT - 1);
		else ylast = Y_BITS'(src_h_q - 1'b1);
	end

	// tap coordinates with edge clamp
	logic [SX_W:0]    rx, ry;
	logic signed [TX_W-1:0] cand_x, cand_y;
	logic [X_BITS-1:0] tap_x;
	logic [Y_BITS-1:0] tap_y;
	always_comb begin
		rx = {1'b0, sx_q} + (SX_W+1)'(ONE / 2);
		ry = {1'b0, sy_q} + (SX_W+1)'(ONE / 2);
		if (state_q == ST_NRD) begin
			cand_x = TX_W'(rx[SX_W:FRAC_BITS]);
			cand_y = TX_W'(ry[SX_W:FRAC_BITS]);
		end else begin
			cand_x = TX_W'(sx_q[SX_W-1:FRAC_BITS]) + TX_W'(n_q) - TX_W'(cubic);
			cand_y = TX_W'(sy_q[SX_W-1:FRAC_BITS]) + TX_W'(m_q) - TX_W'(cubic);
		end
		if (cand_x[TX_W-1]) tap_x = '0;
		else if (cand_x > $signed(TX_W'(xlast))) tap_x = xlast;
		else tap_x = cand_x[X_BITS-1:0];
		if (cand_y[TX_W-1]) tap_y = '0;
		else if (cand_y > $signed(TX_W'(ylast))) tap_y = ylast;
		else tap_y = cand_y[Y_BITS-1:0];
	end

	// frame store
	logic              st_we;
	logic [PIX_W-1:0]  rdata;
	assign st_we = start && !busy && !item.action
		&& (32'(item.coord_x) < MAX_WIDTH) && (32'(item.coord_y) < MAX_HEIGHT);

	ifr_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr ({item.coord_y[Y_BITS-1:0], item.coord_x[X_BITS-1:0]}),
		.wdata ({item.chan_red, item.chan_green, item.chan_blue}),
		.raddr ({tap_y, tap_x}),
		.rdata (rdata)
	);

	// kernel distance for weight k: x taps then y taps
	logic [FRAC_BITS-1:0] kf;
	logic [D_W-1:0]       d;
	always_comb begin
		kf = k_q[2] ? sy_q[FRAC_BITS-1:0] : sx_q[FRAC_BITS-1:0];
		case (k_q[1:0])
			2'd0:    d = D_W'(ONE) + D_W'(kf);
			2'd1:    d = D_W'(kf);
			2'd2:    d = D_W'(ONE) - D_W'(kf);
			default: d = D_W'(2 * ONE) - D_W'(kf);
		endcase
	end

	// shared multiplier
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MX: begin
				mul_a = MA_W'(inv_q);
				mul_b = MB_W'(item_q.coord_x);
			end
			ST_MY: begin
				mul_a = MA_W'(inv_q);
				mul_b = MB_W'(item_q.coord_y);
			end
			ST_KSQ: begin
				mul_a = MA_W'(d);
				mul_b = MB_W'(d);
			end
			ST_KCU: begin
				mul_a = MA_W'(prod[FRAC_BITS +: Q2_W]);
				mul_b = MB_W'(d);
			end
			ST_TW: begin
				mul_a = MA_W'(wy_q[m_q]);
				mul_b = MB_W'(wx_q[n_q]);
			end
			ST_TP0: begin
				mul_a = prod[MA_W-1:0];
				mul_b = MB_W'(rdata[7:0]);
			end
			ST_TP1: begin
				mul_a = w_q;
				mul_b = MB_W'(pix_q[15:8]);
			end
			ST_TP2: begin
				mul_a = w_q;
				mul_b = MB_W'(pix_q[23:16]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ifr_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	// twice the Keys kernel; only the low bits are kept
	logic [KW_W-1:0] kc, kb, ka, kw;
	always_comb begin
		kc = KW_W'(prod[FRAC_BITS +: Q3_W]);
		kb = KW_W'(q2_q);
		ka = KW_W'(d);
		if (d <= D_W'(ONE))
			kw = (kc << 1) + kc - (kb << 2) - kb + KW_W'(2 * ONE);
		else if (d < D_W'(2 * ONE))
			kw = (kb << 2) + kb - kc - (ka << 3) + KW_W'(4 * ONE);
		else
			kw = '0;
	end

	// bilinear: sum >> 2*FRAC_BITS, saturate
	logic [7:0] bil [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (acc_q[i][ACC_W-1:2*FRAC_BITS] > (ACC_W-2*FRAC_BITS)'(255))
				bil[i] = 8'hFF;
			else
				bil[i] = acc_q[i][2*FRAC_BITS +: 8];
		end
	end

	// per-channel division
	logic signed [ACC_W-1:0] acc_c;
	logic                    skip;
	logic                    div_start, div_done;
	logic [7:0]              div_quot, chan_val;
	assign acc_c     = (c_q == 2'd0) ? acc_q[0] : (c_q == 2'd1) ? acc_q[1] : acc_q[2];
	assign skip      = (wsum_q <= 0) || (acc_c <= 0);
	assign div_start = (state_q == ST_DGO) && !skip;
	assign chan_val  = (state_q == ST_DGO) ? 8'd0 : div_quot;

	ifr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_c[DIV_W-1:0]),
		.den    (wsum_q[DIV_W-1:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rvalid_q <= 1'b0;
			src_w_q  <= DIM_W'(1);
			src_h_q  <= DIM_W'(1);
			interp_q <= MODE_NEAREST;
			color_q  <= 1'b1;
			inv_q    <= INV_W'(ONE);
		end else begin
			rvalid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SRC_W:  src_w_q  <= cfg_data[DIM_W-1:0];
					REG_SRC_H:  src_h_q  <= cfg_data[DIM_W-1:0];
					REG_INTERP: interp_q <= cfg_data[1:0];
					REG_COLOR:  color_q  <= cfg_data[0];
					REG_INV:    inv_q    <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start && item.action) begin
						item_q  <= item;
						state_q <= ST_MX;
					end
				end
				ST_MX: state_q <= ST_MY;
				ST_MY: begin
					sx_q    <= prod[SX_W-1:0];
					state_q <= ST_POS;
				end
				ST_POS: begin
					sy_q    <= prod[SX_W-1:0];
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					n_q    <= '0;
					m_q    <= '0;
					k_q    <= '0;
					wsum_q <= '0;
					for (int i = 0; i < 3; i++) acc_q[i] <= '0;
					wx_q[0] <= WT_W'(ONE) - WT_W'(sx_q[FRAC_BITS-1:0]);
					wx_q[1] <= WT_W'(sx_q[FRAC_BITS-1:0]);
					wy_q[0] <= WT_W'(ONE) - WT_W'(sy_q[FRAC_BITS-1:0]);
					wy_q[1] <= WT_W'(sy_q[FRAC_BITS-1:0]);
					if (interp_q == MODE_NEAREST) state_q <= ST_NRD;
					else if (interp_q == MODE_BILINEAR) state_q <= ST_TW;
					else state_q <= ST_KSQ;
				end
				ST_NRD: state_q <= ST_NOUT;
				ST_NOUT: begin
					result_q.out_blue  <= rdata[7:0];
					result_q.out_green <= color_q ? rdata[15:8] : 8'd0;
					result_q.out_red   <= color_q ? rdata[23:16] : 8'd0;
					rvalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_KSQ: state_q <= ST_KCU;
				ST_KCU: begin
					q2_q    <= prod[FRAC_BITS +: Q2_W];
					state_q <= ST_KWT;
				end
				ST_KWT: begin
					if (k_q[2]) wy_q[k_q[1:0]] <= kw[WT_W-1:0];
					else wx_q[k_q[1:0]] <= kw[WT_W-1:0];
					k_q <= k_q + 3'd1;
					state_q <= (k_q == 3'd7) ? ST_TW : ST_KSQ;
				end
				ST_TW: state_q <= ST_TP0;
				ST_TP0: begin
					w_q     <= prod[MA_W-1:0];
					wsum_q  <= wsum_q + prod[ACC_W-1:0];
					pix_q   <= rdata;
					state_q <= ST_TP1;
				end
				ST_TP1: begin
					acc_q[0] <= acc_q[0] + prod[ACC_W-1:0];
					state_q  <= ST_TP2;
				end
				ST_TP2: begin
					acc_q[1] <= acc_q[1] + prod[ACC_W-1:0];
					state_q  <= ST_TP3;
				end
				ST_TP3: begin
					acc_q[2] <= acc_q[2] + prod[ACC_W-1:0];
					state_q  <= ST_TW;
					if (n_q == {cubic, 1'b1}) begin
						n_q <= '0;
						m_q <= m_q + 2'd1;
						if (m_q == {cubic, 1'b1}) state_q <= ST_FIN;
					end else begin
						n_q <= n_q + 2'd1;
					end
				end
				ST_FIN: begin
					c_q <= '0;
					if (cubic) begin
						state_q <= ST_DGO;
					end else begin
						result_q.out_blue  <= bil[0];
						result_q.out_green <= color_q ? bil[1] : 8'd0;
						result_q.out_red   <= color_q ? bil[2] : 8'd0;
						rvalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_DGO, ST_DWAIT: begin
					if (state_q == ST_DGO && !skip) begin
						state_q <= ST_DWAIT;
					end else if (state_q == ST_DGO || div_done) begin
						if (c_q == 2'd0) res0_q <= chan_val;
						if (c_q == 2'd1) res1_q <= chan_val;
						c_q     <= c_q + 2'd1;
						state_q <= ST_DGO;
						if (c_q == 2'd2) begin
							result_q.out_blue  <= res0_q;
							result_q.out_green <= color_q ? res1_q : 8'd0;
							result_q.out_red   <= color_q ? chan_val : 8'd0;
							rvalid_q <= 1'b1;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = rvalid_q;
	assign result       = result_q;

	a_strobe_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe longer than a beat");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.action) |=> !busy && !result_valid)
		else $error("load beat started a request");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action) |=> busy) else $error("request not taken");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !color_q) |-> (result.out_green == 8'd0 && result.out_red == 8'd0))
		else $error("grey result carries color");

endmodule
`default_nettype wire

@@ rtl/ifr_store.sv @@
`default_nettype none
module ifr_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ifr_pkg::ADDR_W-1:0] waddr,
	input  logic [ifr_pkg::PIX_W-1:0]  wdata,
	input  logic [ifr_pkg::ADDR_W-1:0] raddr,
	output logic [ifr_pkg::PIX_W-1:0]  rdata
);
	import ifr_pkg::*;

	logic [PIX_W-1:0] mem_q [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/ifr_mul.sv @@
`default_nettype none
module ifr_mul (
	input  logic                            clk,
	input  logic signed [ifr_pkg::MA_W-1:0] a,
	input  logic signed [ifr_pkg::MB_W-1:0] b,
	output logic signed [ifr_pkg::MP_W-1:0] prod_q
);
	import ifr_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire

@@ rtl/ifr_div.sv @@
`default_nettype none
module ifr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ifr_pkg::DIV_W-1:0] num,
	input  logic [ifr_pkg::DIV_W-1:0] den,
	output logic                      done,
	output logic [7:0]                quot
);
	import ifr_pkg::*;

	logic               run_q;
	logic               done_q;
	logic [2:0]         cnt_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W+6:0]   dsh_q;
	logic [7:0]         quot_q;
	logic               sat;
	logic               ge;

	// quotient of 256 or more saturates
	assign sat = {8'b0, num} >= {den, 8'b0};
	assign ge  = {7'b0, rem_q} >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quot_q <= '0;
				if (sat) begin
					quot_q <= 8'hFF;
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					rem_q <= num;
					dsh_q <= {den, 7'b0};
					cnt_q <= 3'd7;
				end
			end else if (run_q) begin
				if (ge) begin
					rem_q <= rem_q - dsh_q[DIV_W-1:0];
				end
				quot_q <= {quot_q[6:0], ge};
				dsh_q  <= dsh_q >> 1;
				cnt_q  <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire
